// ----- hw/rtl/mrw_pkg.sv -----
// shared types and constants for the miller-rabin witness test unit
// no dependencies; imported by mrw_modmul and miller_rabin_witness_test_unit
package mrw_pkg;

    localparam int MRW_WIDTH = 64;
    localparam int FIELD_WIDTH = 64;

    localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
    localparam logic [1:0] VERDICT_PROBABLE  = 2'd1;
    localparam logic [1:0] VERDICT_INVALID   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_TZ,
        ST_POW_CHK,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_TEST,
        ST_SQ_MUL,
        ST_SQ_CHK,
        ST_FINISH,
        ST_EMIT
    } state_t;

endpackage

// ----- hw/rtl/mrw_modmul.sv -----
// shift-add modular multiplier, one multiplier bit per cycle
// depends on mrw_pkg
module mrw_modmul
    import mrw_pkg::*;
#(
    parameter int WIDTH = MRW_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] multiplicand,
    input  logic [WIDTH-1:0] multiplier,
    input  logic [WIDTH-1:0] modulus,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] n_reg, n_next;

    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH-1:0] step_val;

    // acc = 2*acc mod n, then + a mod n when the current multiplier bit is set
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n_reg}) ? WIDTH'(dbl - {1'b0, n_reg}) : dbl[WIDTH-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, a_reg};
        if (b_reg[WIDTH-1])
        begin
            step_val = (sum >= {1'b0, n_reg}) ? WIDTH'(sum - {1'b0, n_reg}) : sum[WIDTH-1:0];
        end
        else
        begin
            step_val = dbl_red;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        n_next    = n_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH - 1);
            acc_next  = '0;
            a_next    = multiplicand;
            b_next    = multiplier;
            n_next    = modulus;
        end
        else if (busy_reg)
        begin
            acc_next = step_val;
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        n_reg   <= n_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a preceding step");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (acc_reg < n_reg))
        else $error("accumulator left the residue range");

endmodule

// ----- hw/rtl/miller_rabin_witness_test_unit.sv -----
// miller-rabin witness test unit: one round per input transaction
// input channel: in_valid/in_ready with candidate, witness, final_round
// output channel: out_valid/out_ready with verdict (0 composite, 1 probable
// prime, 2 invalid candidate)
// a round reduces the witness mod n, counts the trailing zeros k of n-1,
// raises the witness to m = (n-1)>>k and squares up to k-1 more times
// every modular product runs on one shared shift-add multiplier
// a zero witness skips the exponentiation and the squarings and passes
// an even candidate or one below 3 goes straight to the verdict invalid
// in_ready is high only while the sequencer is idle
// verdicts go to an output register, so the next transaction is taken while
// a verdict waits; a stalled receiver holds the sequencer, and so the input,
// only once a second verdict is ready
// non-final rounds of a valid candidate give no verdict, they only clear the pass flag on failure
// reset empties the output register and sets the pass flag
// depends on mrw_pkg and mrw_modmul
module miller_rabin_witness_test_unit
    import mrw_pkg::*;
#(
    parameter int WIDTH = MRW_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FIELD_WIDTH-1:0] candidate,
    input  logic [FIELD_WIDTH-1:0] witness,
    input  logic                   final_round,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             verdict
);

    localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    state_t state_reg, state_next;

    logic             all_passed_reg, all_passed_next;
    logic             round_pass_reg, round_pass_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       verdict_reg, verdict_next;
    logic [1:0]       pend_reg, pend_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] nm1_reg, nm1_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [KW-1:0]    k_reg, k_next;

    logic [WIDTH-1:0] cand_w;
    logic [WIDTH-1:0] wit_w;
    logic             cand_bad;
    logic             accept;
    logic             out_free;
    logic             pass_all;

    logic             mul_start;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_n;
    logic             mul_busy;
    logic             mul_done;
    logic [WIDTH-1:0] mul_prod;

    assign cand_w   = candidate[WIDTH-1:0];
    assign wit_w    = witness[WIDTH-1:0];
    assign cand_bad = (cand_w < WIDTH'(3)) || !cand_w[0];
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign pass_all = all_passed_reg && round_pass_reg;

    mrw_modmul #(
        .WIDTH(WIDTH)
    ) u_modmul (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mul_start),
        .multiplicand(mul_a),
        .multiplier  (mul_b),
        .modulus     (mul_n),
        .busy        (mul_busy),
        .done        (mul_done),
        .product     (mul_prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cand_bad ? ST_EMIT : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    state_next = (mul_prod == '0) ? ST_FINISH : ST_TZ;
                end
            end
            ST_TZ:
            begin
                if (e_reg[0])
                begin
                    state_next = ST_POW_CHK;
                end
            end
            ST_POW_CHK:
            begin
                priority if (e_reg == '0)
                begin
                    state_next = ST_TEST;
                end
                else if (e_reg[0])
                begin
                    state_next = ST_POW_MUL;
                end
                else
                begin
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                if (mul_done)
                begin
                    state_next = ST_POW_CHK;
                end
            end
            ST_TEST:
            begin
                priority if ((r_reg == WIDTH'(1)) || (r_reg == nm1_reg) || (k_reg <= KW'(1)))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK:
            begin
                priority if ((r_reg == WIDTH'(1)) || (r_reg == nm1_reg) || (k_reg <= KW'(1)))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_FINISH:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and multiplier commands
    always_comb
    begin
        all_passed_next = all_passed_reg;
        round_pass_next = round_pass_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        verdict_next    = verdict_reg;
        pend_next       = pend_reg;
        n_next          = n_reg;
        nm1_next        = nm1_reg;
        base_next       = base_reg;
        r_next          = r_reg;
        e_next          = e_reg;
        k_next          = k_reg;
        mul_start       = 1'b0;
        mul_a           = base_reg;
        mul_b           = base_reg;
        mul_n           = n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next    = cand_w;
                    nm1_next  = cand_w - WIDTH'(1);
                    e_next    = cand_w - WIDTH'(1);
                    k_next    = '0;
                    last_next = final_round;
                    if (cand_bad)
                    begin
                        all_passed_next = 1'b1;
                        pend_next       = VERDICT_INVALID;
                    end
                    else
                    begin
                        // witness mod n as 1 * witness mod n
                        mul_start = 1'b1;
                        mul_a     = WIDTH'(1);
                        mul_b     = wit_w;
                        mul_n     = cand_w;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    base_next = mul_prod;
                    // zero witness carries no evidence
                    round_pass_next = 1'b1;
                end
            end
            ST_TZ:
            begin
                if (e_reg[0])
                begin
                    r_next = WIDTH'(1);
                end
                else
                begin
                    e_next = e_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
            end
            ST_POW_CHK:
            begin
                if (e_reg != '0)
                begin
                    mul_start = 1'b1;
                    mul_a     = e_reg[0] ? r_reg : base_reg;
                    mul_b     = base_reg;
                end
            end
            ST_POW_MUL:
            begin
                if (mul_done)
                begin
                    r_next    = mul_prod;
                    mul_start = 1'b1;
                    mul_a     = base_reg;
                    mul_b     = base_reg;
                end
            end
            ST_POW_SQR:
            begin
                if (mul_done)
                begin
                    base_next = mul_prod;
                    e_next    = e_reg >> 1;
                end
            end
            ST_TEST:
            begin
                priority if ((r_reg == WIDTH'(1)) || (r_reg == nm1_reg))
                begin
                    round_pass_next = 1'b1;
                end
                else if (k_reg <= KW'(1))
                begin
                    round_pass_next = 1'b0;
                end
                else
                begin
                    k_next    = k_reg - 1'b1;
                    mul_start = 1'b1;
                    mul_a     = r_reg;
                    mul_b     = r_reg;
                end
            end
            ST_SQ_MUL:
            begin
                if (mul_done)
                begin
                    r_next = mul_prod;
                end
            end
            ST_SQ_CHK:
            begin
                // reaching 1 before n-1 means a nontrivial square root of 1
                priority if (r_reg == WIDTH'(1))
                begin
                    round_pass_next = 1'b0;
                end
                else if (r_reg == nm1_reg)
                begin
                    round_pass_next = 1'b1;
                end
                else if (k_reg <= KW'(1))
                begin
                    round_pass_next = 1'b0;
                end
                else
                begin
                    k_next    = k_reg - 1'b1;
                    mul_start = 1'b1;
                    mul_a     = r_reg;
                    mul_b     = r_reg;
                end
            end
            ST_FINISH:
            begin
                if (last_reg)
                begin
                    pend_next       = pass_all ? VERDICT_PROBABLE : VERDICT_COMPOSITE;
                    all_passed_next = 1'b1;
                end
                else
                begin
                    all_passed_next = pass_all;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = pend_reg;
                end
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            all_passed_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            all_passed_reg <= all_passed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_pass_reg <= round_pass_next;
        last_reg       <= last_next;
        verdict_reg    <= verdict_next;
        pend_reg       <= pend_next;
        n_reg          <= n_next;
        nm1_reg        <= nm1_next;
        base_reg       <= base_next;
        r_reg          <= r_next;
        e_reg          <= e_next;
        k_reg          <= k_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mul_busy)
        else $error("multiplier busy while sequencer idle");

    a_flag_set_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> all_passed_reg)
        else $error("pass flag not restored before verdict");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((verdict_reg == VERDICT_COMPOSITE) ||
                           (verdict_reg == VERDICT_PROBABLE) ||
                           (verdict_reg == VERDICT_INVALID)))
        else $error("verdict register holds an unused code");

endmodule

// ----- tb/sv/miller_rabin_witness_test_unit_test.sv -----
// self-checking testbench for miller_rabin_witness_test_unit
// drives rounds of candidate/witness pairs, predicts each verdict with a
// 128-bit modular arithmetic model; depends on mrw_pkg and the unit's rtl
module miller_rabin_witness_test_unit_test;
    import mrw_pkg::*;

    localparam int W = MRW_WIDTH;
    localparam int N_DIRECTED = 25;
    localparam int RANDOM_ITEMS = 75;
    localparam int STALL_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 16384;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] cand;
        logic [FIELD_WIDTH-1:0] wit;
        logic                   fin;
        logic                   fixed;
        logic [1:0]             verdict;
    } stim_row_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] cand;
        logic [1:0]             verdict;
    } verdict_entry_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [FIELD_WIDTH-1:0] candidate;
    logic [FIELD_WIDTH-1:0] witness;
    logic                   final_round;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             verdict;

    verdict_entry_t pending_verdicts[$];
    stim_row_t      directed_rows [N_DIRECTED];
    logic           rounds_ok;
    logic           in_no_idle;
    logic           out_no_idle;
    int             error_count;
    int             idle_cycles;

    miller_rabin_witness_test_unit #(
        .WIDTH(W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .candidate(candidate),
        .witness(witness),
        .final_round(final_round),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .verdict(verdict)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] n);
        logic [127:0] prod;
        logic [127:0] rem;
        prod = {64'd0, a} * {64'd0, b};
        rem = prod % {64'd0, n};
        return rem[63:0];
    endfunction

    function automatic logic [63:0] pow_mod(input logic [63:0] base, input logic [63:0] e,
                                            input logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] b;
        logic [63:0] ex;
        acc = 64'd1;
        b = base;
        ex = e;
        while (ex != 64'd0)
        begin
            if (ex[0])
                acc = mul_mod(acc, b, n);
            b = mul_mod(b, b, n);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // strong probable prime test of n to base a, with a already below n
    function automatic logic witness_round_passes(input logic [63:0] n, input logic [63:0] a);
        logic [63:0] nm1;
        logic [63:0] m;
        logic [63:0] x;
        int          k;
        nm1 = n - 64'd1;
        m = nm1;
        k = 0;
        if (a == 64'd0)
            return 1'b1;
        while (!m[0])
        begin
            m = m >> 1;
            k++;
        end
        x = pow_mod(a, m, n);
        if (x == 64'd1 || x == nm1)
            return 1'b1;
        for (int j = 1; j < k; j++)
        begin
            x = mul_mod(x, x, n);
            if (x == 64'd1)
                return 1'b0;
            if (x == nm1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_verdict(input logic [63:0] cand, input logic [63:0] wit,
                                   input logic fin, output logic has_verdict,
                                   output logic [1:0] v);
        logic [63:0] word_mask;
        logic [63:0] n;
        logic [63:0] a;
        logic        pass;
        word_mask = (W >= 64) ? {64{1'b1}} : ((64'd1 << W) - 64'd1);
        n = cand & word_mask;
        a = wit & word_mask;
        has_verdict = 1'b1;
        v = VERDICT_INVALID;
        if (n < 64'd3 || !n[0])
        begin
            // candidate dropped, flag starts over
            rounds_ok = 1'b1;
            return;
        end
        pass = witness_round_passes(n, a % n);
        rounds_ok = rounds_ok && pass;
        if (!fin)
        begin
            has_verdict = 1'b0;
            return;
        end
        v = rounds_ok ? VERDICT_PROBABLE : VERDICT_COMPOSITE;
        rounds_ok = 1'b1;
    endtask

    task automatic send_round(input logic [63:0] cand, input logic [63:0] wit, input logic fin,
                              input logic fixed, input logic [1:0] fixed_verdict);
        int             gap;
        logic           has_verdict;
        logic [1:0]     v;
        verdict_entry_t entry;
        if ($urandom_range(0, 15) == 0)
            in_no_idle = ~in_no_idle;
        gap = in_no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        candidate <= cand;
        witness <= wit;
        final_round <= fin;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        predict_verdict(cand, wit, fin, has_verdict, v);
        if (has_verdict)
        begin
            entry.cand = cand;
            entry.verdict = fixed ? fixed_verdict : v;
            pending_verdicts.push_back(entry);
        end
    endtask

    function automatic logic [63:0] pick_prime();
        case ($urandom_range(0, 7))
            0: return 64'd3;
            1: return 64'd65537;
            2: return 64'd2147483647;
            3: return 64'd4294967291;
            4: return 64'd1000000007;
            5: return 64'd998244353;
            6: return 64'h1FFF_FFFF_FFFF_FFFF;
            default: return 64'hFFFF_FFFF_FFFF_FFC5;
        endcase
    endfunction

    // carmichael numbers, strong pseudoprimes and fermat composites
    function automatic logic [63:0] pick_tricky();
        case ($urandom_range(0, 7))
            0: return 64'd2047;
            1: return 64'd561;
            2: return 64'd341;
            3: return 64'd1373653;
            4: return 64'd3215031751;
            5: return 64'd25326001;
            6: return 64'd4294967297;
            default: return 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    function automatic logic [63:0] pick_candidate();
        logic [63:0] v;
        int          len;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: v = pick_prime();
            3, 4: v = pick_tricky();
            5, 6, 7:
            begin
                // mostly short candidates keep the exponent short
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 32) : $urandom_range(33, 64);
                if (len < 64)
                    v = v & ((64'd1 << len) - 64'd1);
                v[len-1] = 1'b1;
                v[0] = 1'b1;
            end
            default:
            begin
                // n-1 with many trailing zeros gives long squaring chains
                v = (v << $urandom_range(1, 48)) | 64'd1;
            end
        endcase
        return v;
    endfunction

    function automatic logic [63:0] pick_witness(input logic [63:0] n);
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return n;
            3: return n - 64'd1;
            4, 5: return 64'($urandom_range(2, 40));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result side: random back-pressure and in-order compare
    initial
    begin
        int             stall;
        verdict_entry_t exp_entry;
        out_no_idle = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                out_no_idle = ~out_no_idle;
            stall = out_no_idle ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            if (pending_verdicts.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected verdict %0d with nothing pending", verdict);
            end
            else
            begin
                exp_entry = pending_verdicts.pop_front();
                if (verdict !== exp_entry.verdict)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("verdict mismatch for candidate %0d: expected %0d, got %0d",
                                 exp_entry.cand, exp_entry.verdict, verdict);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int          items;
        int          rounds;
        logic [63:0] n;
        logic [63:0] noise_cand;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        candidate = '0;
        witness = '0;
        final_round = 1'b0;
        rounds_ok = 1'b1;
        in_no_idle = 1'b0;
        error_count = 0;
        idle_cycles = 0;

        // verdict column only counts where fixed is set
        directed_rows = '{
            '{64'd0, 64'd5, 1'b1, 1'b1, VERDICT_INVALID},
            '{64'd1, 64'd0, 1'b0, 1'b1, VERDICT_INVALID},
            '{64'd2, 64'd1, 1'b1, 1'b1, VERDICT_INVALID},
            '{64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, VERDICT_INVALID},
            '{64'd3, 64'd2, 1'b1, 1'b1, VERDICT_PROBABLE},
            '{64'd65537, 64'd3, 1'b1, 1'b1, VERDICT_PROBABLE},
            '{64'hFFFF_FFFF_FFFF_FFC5, 64'd2, 1'b1, 1'b1, VERDICT_PROBABLE},
            '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, VERDICT_COMPOSITE},
            '{64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'd15, 64'd15, 1'b0, 1'b0, VERDICT_COMPOSITE},
            '{64'd15, 64'd14, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'd2047, 64'd2, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'd2047, 64'd1, 1'b0, 1'b0, VERDICT_COMPOSITE},
            '{64'd2047, 64'd3, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'd561, 64'd2, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'd3215031751, 64'd2, 1'b0, 1'b0, VERDICT_COMPOSITE},
            '{64'd3215031751, 64'd3, 1'b0, 1'b0, VERDICT_COMPOSITE},
            '{64'd3215031751, 64'd5, 1'b0, 1'b0, VERDICT_COMPOSITE},
            '{64'd3215031751, 64'd7, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'd25, 64'd7, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'd561, 64'd2, 1'b0, 1'b0, VERDICT_COMPOSITE},
            '{64'd4, 64'd3, 1'b0, 1'b1, VERDICT_INVALID},
            '{64'd65537, 64'd5, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'h1FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b1, 1'b0, VERDICT_COMPOSITE},
            '{64'h8000_0000_0000_0001, 64'd3, 1'b1, 1'b0, VERDICT_COMPOSITE}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_round(directed_rows[i].cand, directed_rows[i].wit, directed_rows[i].fin,
                       directed_rows[i].fixed, directed_rows[i].verdict);

        // full witness sequences per candidate, with some stray transactions
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                noise_cand = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 4))
                                                          : {$urandom, $urandom};
                send_round(noise_cand, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                           1'b0, VERDICT_COMPOSITE);
                items++;
            end
            else
            begin
                n = pick_candidate();
                rounds = $urandom_range(1, 4);
                for (int r = 0; r < rounds; r++)
                begin
                    send_round(n, pick_witness(n), r == rounds - 1, 1'b0, VERDICT_COMPOSITE);
                    items++;
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
